### src/selected_axis_gather_index_core_assert.svh
// Assertion macros used by the checker module.
`ifndef SELECTED_AXIS_GATHER_INDEX_CORE_ASSERT_SVH
`define SELECTED_AXIS_GATHER_INDEX_CORE_ASSERT_SVH

// Same-cycle implication.
`define SAGI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SAGI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/sagi_pkg.sv
`timescale 1ns / 1ps
package sagi_pkg;

   localparam int MAX_AXES       = 4;
   localparam int MAX_CHOSEN     = 8;
   localparam int EXTENT_BITS    = 12;
   localparam int IDX_BITS       = 48;
   localparam int DIV_BITS       = 4;
   localparam int CELLS_PER_AXIS = IDX_BITS / DIV_BITS;
   localparam int DIV_CELLS      = MAX_AXES * CELLS_PER_AXIS;
   localparam int ALL_CELLS      = DIV_CELLS + 2 * MAX_AXES;
   localparam int HALF_BITS      = IDX_BITS / 2;
   localparam int PROD_BITS      = HALF_BITS + EXTENT_BITS;

   typedef enum logic [2:0] {
      REG_AXIS_COUNT     = 3'd0,
      REG_EXTENT0        = 3'd1,
      REG_EXTENT1        = 3'd2,
      REG_EXTENT2        = 3'd3,
      REG_EXTENT3        = 3'd4,
      REG_CHOSEN_AXIS    = 3'd5,
      REG_CHOSEN_COUNT   = 3'd6,
      REG_POSITION_TABLE = 3'd7
   } reg_index_type;

   // One word in flight through the cell chain.
   // num: dividend/quotient during division, source index during recombine.
   typedef struct packed {
      logic [IDX_BITS-1:0]                     num;
      logic [EXTENT_BITS-1:0]                  part;
      logic [MAX_AXES-1:0][EXTENT_BITS-1:0]    coord;
      logic                                    bad;
      logic [PROD_BITS-1:0]                    plo;
      logic [HALF_BITS-1:0]                    phi;
   } word_type;

endpackage

### src/sagi_div_cell.sv
`timescale 1ns / 1ps
// Restoring divider slice: DIV_BITS quotient bits per cell.
module sagi_div_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  sagi_pkg::word_type                 in_word,
   input  logic [sagi_pkg::EXTENT_BITS-1:0]   divisor,
   output logic                               out_valid,
   input  logic                               out_ready,
   output sagi_pkg::word_type                 out_word
);

   logic               valid_ff, valid_in;
   sagi_pkg::word_type word_ff, word_in, step;

   always_comb begin
      logic [sagi_pkg::EXTENT_BITS:0] t;
      logic                           q;
      step = in_word;
      for (int s = 0; s < sagi_pkg::DIV_BITS; s++) begin
         t = {step.part, step.num[sagi_pkg::IDX_BITS-1]};
         q = (t >= {1'b0, divisor});
         step.num = {step.num[sagi_pkg::IDX_BITS-2:0], q};
         if (q) begin
            t = t - {1'b0, divisor};
         end
         step.part = t[sagi_pkg::EXTENT_BITS-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign word_in  = in_ready ? step : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### src/sagi_mul_cell.sv
`timescale 1ns / 1ps
// Recombine, first half: source index times extent as two half-width products.
module sagi_mul_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  sagi_pkg::word_type                 in_word,
   input  logic [sagi_pkg::EXTENT_BITS-1:0]   extent,
   output logic                               out_valid,
   input  logic                               out_ready,
   output sagi_pkg::word_type                 out_word
);

   logic                            valid_ff, valid_in;
   sagi_pkg::word_type              word_ff, word_in, step;
   logic [sagi_pkg::PROD_BITS-1:0]  hi_full;

   always_comb begin
      step     = in_word;
      step.plo = {{sagi_pkg::EXTENT_BITS{1'b0}}, in_word.num[sagi_pkg::HALF_BITS-1:0]}
                 * {{sagi_pkg::HALF_BITS{1'b0}}, extent};
      hi_full  = {{sagi_pkg::EXTENT_BITS{1'b0}},
                  in_word.num[sagi_pkg::IDX_BITS-1:sagi_pkg::HALF_BITS]}
                 * {{sagi_pkg::HALF_BITS{1'b0}}, extent};
      step.phi = hi_full[sagi_pkg::HALF_BITS-1:0];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign word_in  = in_ready ? step : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### src/sagi_acc_cell.sv
`timescale 1ns / 1ps
// Recombine, second half: merge partial products and add the coordinate.
module sagi_acc_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  sagi_pkg::word_type                 in_word,
   input  logic [sagi_pkg::EXTENT_BITS-1:0]   coord,
   output logic                               out_valid,
   input  logic                               out_ready,
   output sagi_pkg::word_type                 out_word
);

   logic               valid_ff, valid_in;
   sagi_pkg::word_type word_ff, word_in, step;

   always_comb begin
      step     = in_word;
      step.num = {in_word.phi, {sagi_pkg::HALF_BITS{1'b0}}}
               + {{(sagi_pkg::IDX_BITS-sagi_pkg::PROD_BITS){1'b0}}, in_word.plo}
               + {{(sagi_pkg::IDX_BITS-sagi_pkg::EXTENT_BITS){1'b0}}, coord};
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign word_in  = in_ready ? step : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### src/selected_axis_gather_index_core.sv
`timescale 1ns / 1ps
// Gather index remap for selecting entries along one axis of a row-major array.
// req_ channel: one output-array linear index per word (req_out_index).
// rsp_ channel: the matching source-array index (rsp_src_index) and an
//   out-of-range flag; an out-of-range index returns source index 0.
// csr_ port: APB-style, 64-bit data, register i at byte address 8*i.
//   Write registers only while no word is in flight; the block does not enforce this.
// Throughput: one word per cycle while the receiver takes every response.
// Path from request accept to response valid: 48 registered divider cells
//   (4 quotient bits each, 12 per axis, innermost axis first) then a multiply
//   cell and an add cell per axis for the recombine.
// Each cell holds one word; a cell takes a new word whenever it is empty or its
//   neighbor takes its word, so bubbles collapse and requests keep flowing while
//   a response waits, until the chain is full.
// Reset (synchronous) empties the chain and loads the register reset values.
// When the receiver stalls, the response holds steady until taken.
module selected_axis_gather_index_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sagi_pkg::IDX_BITS-1:0]     req_out_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sagi_pkg::IDX_BITS-1:0]     rsp_src_index,
   output logic                              rsp_out_of_range,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [5:0]                        csr_paddr,
   input  logic [63:0]                       csr_pwdata,
   output logic [63:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int EB = sagi_pkg::EXTENT_BITS;
   localparam int NC = sagi_pkg::ALL_CELLS;
   localparam int NA = sagi_pkg::MAX_AXES;

   // ---------------- configuration registers ----------------
   logic [2:0]                axis_count_ff;
   logic [NA-1:0][EB-1:0]     extent_ff;
   logic [1:0]                chosen_axis_ff;
   logic [3:0]                chosen_count_ff;
   logic [63:0]               position_table_ff;

   sagi_pkg::reg_index_type   csr_index;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = sagi_pkg::reg_index_type'(csr_paddr[5:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_count_ff     <= 3'd1;
         extent_ff         <= {NA{12'd1}};
         chosen_axis_ff    <= 2'd0;
         chosen_count_ff   <= 4'd1;
         position_table_ff <= 64'd0;
      end else if (csr_write) begin
         case (csr_index)
            sagi_pkg::REG_AXIS_COUNT:     axis_count_ff     <= csr_pwdata[2:0];
            sagi_pkg::REG_EXTENT0:        extent_ff[0]      <= csr_pwdata[EB-1:0];
            sagi_pkg::REG_EXTENT1:        extent_ff[1]      <= csr_pwdata[EB-1:0];
            sagi_pkg::REG_EXTENT2:        extent_ff[2]      <= csr_pwdata[EB-1:0];
            sagi_pkg::REG_EXTENT3:        extent_ff[3]      <= csr_pwdata[EB-1:0];
            sagi_pkg::REG_CHOSEN_AXIS:    chosen_axis_ff    <= csr_pwdata[1:0];
            sagi_pkg::REG_CHOSEN_COUNT:   chosen_count_ff   <= csr_pwdata[3:0];
            sagi_pkg::REG_POSITION_TABLE: position_table_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sagi_pkg::REG_AXIS_COUNT:     csr_prdata = {61'd0, axis_count_ff};
         sagi_pkg::REG_EXTENT0:        csr_prdata = {52'd0, extent_ff[0]};
         sagi_pkg::REG_EXTENT1:        csr_prdata = {52'd0, extent_ff[1]};
         sagi_pkg::REG_EXTENT2:        csr_prdata = {52'd0, extent_ff[2]};
         sagi_pkg::REG_EXTENT3:        csr_prdata = {52'd0, extent_ff[3]};
         sagi_pkg::REG_CHOSEN_AXIS:    csr_prdata = {62'd0, chosen_axis_ff};
         sagi_pkg::REG_CHOSEN_COUNT:   csr_prdata = {60'd0, chosen_count_ff};
         sagi_pkg::REG_POSITION_TABLE: csr_prdata = position_table_ff;
         default:                      csr_prdata = 64'd0;
      endcase
   end

   // ---------------- per-axis divisors and extents ----------------
   // Axes beyond the count in use act as extent 1 with coordinate 0, which
   // leaves both the split and the recombine unchanged.
   logic [2:0]            n_eff;
   logic [3:0]            cnt_sat;
   logic                  sel_used;
   logic [NA-1:0][EB-1:0] div_e;     // divisor fed to the divider cells
   logic [NA-1:0]         zero_e;    // output extent is zero: flag out of range
   logic [NA-1:0][EB-1:0] rec_e;     // source extent for recombine

   always_comb begin
      logic [EB-1:0] e;
      logic          used;
      if (axis_count_ff == 3'd0) begin
         n_eff = 3'd1;
      end else if (axis_count_ff > 3'(NA)) begin
         n_eff = 3'(NA);
      end else begin
         n_eff = axis_count_ff;
      end
      cnt_sat  = (chosen_count_ff > 4'(sagi_pkg::MAX_CHOSEN)) ?
                 4'(sagi_pkg::MAX_CHOSEN) : chosen_count_ff;
      sel_used = ({1'b0, chosen_axis_ff} < n_eff);
      for (int a = 0; a < NA; a++) begin
         used = (3'(a) < n_eff);
         if (!used) begin
            e = 12'd1;
         end else if (sel_used && (chosen_axis_ff == 2'(a))) begin
            e = {8'd0, cnt_sat};
         end else begin
            e = extent_ff[a];
         end
         zero_e[a] = (e == '0);
         div_e[a]  = (e == '0) ? 12'd1 : e;
         rec_e[a]  = used ? extent_ff[a] : 12'd1;
      end
   end

   // ---------------- cell chain ----------------
   logic               c_valid [0:NC];
   logic               c_ready [0:NC];
   sagi_pkg::word_type c_word  [0:NC];
   sagi_pkg::word_type xf_word [0:NC-1];

   always_comb begin
      c_word[0]       = '0;
      c_word[0].num   = req_out_index;
   end
   assign c_valid[0] = req_valid;
   assign req_ready  = c_ready[0];

   genvar k;
   generate
      for (k = 0; k < sagi_pkg::DIV_CELLS; k++) begin : g_div
         localparam int AX = NA - 1 - k / sagi_pkg::CELLS_PER_AXIS;
         if (k % sagi_pkg::CELLS_PER_AXIS == 0) begin : g_head
            // Axis boundary: latch finished remainder as previous axis coordinate.
            always_comb begin
               xf_word[k]      = c_word[k];
               xf_word[k].part = '0;
               xf_word[k].bad  = c_word[k].bad | zero_e[AX];
               if (k != 0) begin
                  xf_word[k].coord[(AX + 1) % NA] = c_word[k].part;
               end
            end
         end else begin : g_body
            assign xf_word[k] = c_word[k];
         end
         sagi_div_cell u_div (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_word   (xf_word[k]),
            .divisor   (div_e[AX]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_word  (c_word[k+1])
         );
      end

      // End of split: last coordinate, leftover quotient check, table swap.
      always_comb begin
         logic [EB-1:0] k_pos;
         xf_word[sagi_pkg::DIV_CELLS]          = c_word[sagi_pkg::DIV_CELLS];
         xf_word[sagi_pkg::DIV_CELLS].coord[0] = c_word[sagi_pkg::DIV_CELLS].part;
         xf_word[sagi_pkg::DIV_CELLS].bad      = c_word[sagi_pkg::DIV_CELLS].bad
                                               | (c_word[sagi_pkg::DIV_CELLS].num != '0);
         xf_word[sagi_pkg::DIV_CELLS].num      = '0;
         k_pos = xf_word[sagi_pkg::DIV_CELLS].coord[chosen_axis_ff];
         if (sel_used) begin
            if (k_pos < EB'(8)) begin
               xf_word[sagi_pkg::DIV_CELLS].coord[chosen_axis_ff] =
                  {4'd0, position_table_ff[{k_pos[2:0], 3'b000} +: 8]};
            end else begin
               xf_word[sagi_pkg::DIV_CELLS].coord[chosen_axis_ff] = '0;
            end
         end
      end

      for (k = 0; k < NA; k++) begin : g_rec
         localparam int M = sagi_pkg::DIV_CELLS + 2 * k;
         if (k != 0) begin : g_link
            assign xf_word[M] = c_word[M];
         end
         assign xf_word[M+1] = c_word[M+1];
         sagi_mul_cell u_mul (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (c_valid[M]),
            .in_ready  (c_ready[M]),
            .in_word   (xf_word[M]),
            .extent    (rec_e[k]),
            .out_valid (c_valid[M+1]),
            .out_ready (c_ready[M+1]),
            .out_word  (c_word[M+1])
         );
         sagi_acc_cell u_acc (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (c_valid[M+1]),
            .in_ready  (c_ready[M+1]),
            .in_word   (xf_word[M+1]),
            .coord     (c_word[M+1].coord[k]),
            .out_valid (c_valid[M+2]),
            .out_ready (c_ready[M+2]),
            .out_word  (c_word[M+2])
         );
      end
   endgenerate

   assign rsp_valid        = c_valid[NC];
   assign c_ready[NC]      = rsp_ready;
   assign rsp_out_of_range = c_word[NC].bad;
   assign rsp_src_index    = c_word[NC].bad ? '0 : c_word[NC].num;

endmodule

### src/sagi_checker.sv
`timescale 1ns / 1ps
`include "selected_axis_gather_index_core_assert.svh"
module sagi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [sagi_pkg::IDX_BITS-1:0]     rsp_src_index,
   input logic                              rsp_out_of_range
);

   // Stalled response word holds.
   `SAGI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_src_index) && $stable(rsp_out_of_range))
   // Out-of-range words carry source index zero.
   `SAGI_ASSERT_NOW(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_src_index == '0)
   // Reset empties the chain.
   `SAGI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // With the output stage empty, every cell can move, so input is taken.
   `SAGI_ASSERT_NOW(a_empty_ready, clock, reset, !rsp_valid, req_ready)

endmodule

bind selected_axis_gather_index_core sagi_checker u_sagi_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// Scoreboard for the gather index remap: predicts each source index from the
// current register copy and checks responses in order.
class gather_scoreboard;
   logic [2:0]  axis_count;
   logic [11:0] extent [4];
   logic [1:0]  chosen_axis;
   logic [3:0]  chosen_count;
   logic [63:0] position_table;
   logic [48:0] pending_q [$];   // {out_of_range, src_index}
   int          mismatches;

   function new();
      axis_count = 1;
      foreach (extent[i]) extent[i] = 1;
      chosen_axis = 0;
      chosen_count = 1;
      position_table = 0;
      mismatches = 0;
   endfunction

   function void write_reg(sagi_pkg::reg_index_type idx, logic [63:0] v);
      case (idx)
         sagi_pkg::REG_AXIS_COUNT:     axis_count = v[2:0];
         sagi_pkg::REG_EXTENT0:        extent[0] = v[11:0];
         sagi_pkg::REG_EXTENT1:        extent[1] = v[11:0];
         sagi_pkg::REG_EXTENT2:        extent[2] = v[11:0];
         sagi_pkg::REG_EXTENT3:        extent[3] = v[11:0];
         sagi_pkg::REG_CHOSEN_AXIS:    chosen_axis = v[1:0];
         sagi_pkg::REG_CHOSEN_COUNT:   chosen_count = v[3:0];
         sagi_pkg::REG_POSITION_TABLE: position_table = v;
         default: ;
      endcase
   endfunction

   function void note_request(logic [47:0] out_index);
      logic [63:0] rem, e, src;
      logic [63:0] coord [4];
      int n, cnt;
      bit sel_used, bad;
      rem = {16'd0, out_index};
      n = axis_count;
      if (n == 0) n = 1;
      if (n > 4) n = 4;
      cnt = chosen_count;
      if (cnt > 8) cnt = 8;
      sel_used = chosen_axis < n;
      bad = 0;
      src = 0;
      for (int i = n - 1; i >= 0; i--) begin
         e = (sel_used && i == chosen_axis) ? cnt : extent[i];
         if (e == 0) begin
            bad = 1;
            coord[i] = 0;
         end else begin
            coord[i] = rem % e;
            rem = rem / e;
         end
      end
      if (rem != 0) bad = 1;
      if (bad) begin
         pending_q.push_back({1'b1, 48'd0});
      end else begin
         if (sel_used)
            coord[chosen_axis] = (coord[chosen_axis] >= 8) ? 0 :
               (position_table >> (8 * coord[chosen_axis])) & 64'hFF;
         for (int i = 0; i < n; i++)
            src = (src * extent[i] + coord[i]) & 64'hFFFF_FFFF_FFFF;
         pending_q.push_back({1'b0, src[47:0]});
      end
   endfunction

   function void check_response(logic [47:0] src_index, logic out_of_range);
      logic [48:0] want;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response src=%h oor=%b", src_index, out_of_range);
         return;
      end
      want = pending_q.pop_front();
      if (want[47:0] !== src_index || want[48] !== out_of_range) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected src=%h oor=%b, got src=%h oor=%b",
                     want[47:0], want[48], src_index, out_of_range);
      end
   endfunction
endclass

module testbench;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [47:0] req_out_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [47:0] rsp_src_index;
   logic        rsp_out_of_range;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   gather_scoreboard sb;
   bit  hold_off;       // long receiver stall requested by the sender side

   selected_axis_gather_index_core dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Watchdog: generous bound for ~2000 words with the widest random gaps on both sides.
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Register write: idle cycle, setup cycle, then access cycle; pready is
   // always high.
   task automatic csr_write(sagi_pkg::reg_index_type idx, logic [63:0] v);
      @(negedge clock);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= 6'(idx) << 3;
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic load_config(logic [2:0] n, logic [11:0] e0, logic [11:0] e1,
                              logic [11:0] e2, logic [11:0] e3, logic [1:0] ax,
                              logic [3:0] cnt, logic [63:0] tbl);
      csr_write(sagi_pkg::REG_AXIS_COUNT, 64'(n));
      csr_write(sagi_pkg::REG_EXTENT0, 64'(e0));
      csr_write(sagi_pkg::REG_EXTENT1, 64'(e1));
      csr_write(sagi_pkg::REG_EXTENT2, 64'(e2));
      csr_write(sagi_pkg::REG_EXTENT3, 64'(e3));
      csr_write(sagi_pkg::REG_CHOSEN_AXIS, 64'(ax));
      csr_write(sagi_pkg::REG_CHOSEN_COUNT, 64'(cnt));
      csr_write(sagi_pkg::REG_POSITION_TABLE, tbl);
   endtask

   // Offer one word, keep it steady until taken; gap is drawn per word.
   // Valid is left high after the accept; the next word or drain() moves it.
   task automatic send_word(logic [47:0] idx, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1;
      req_out_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(idx);
      @(negedge clock);
   endtask

   // Back-to-back variant: valid stays high across words.
   task automatic send_burst(int count);
      for (int i = 0; i < count; i++) begin
         req_valid     <= 1;
         req_out_index <= 48'($urandom_range(0, 600));
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sb.note_request(req_out_index);
         @(negedge clock);
      end
   endtask

   // Wait for every expected word, then let the pipe drain.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   // Random output index: mostly inside the output element count.
   function automatic logic [47:0] pick_index(longint total);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 48'({$urandom, $urandom});
      if (r == 1) return 48'(total + $urandom_range(0, 3));
      if (total <= 0) return 48'($urandom_range(0, 5));
      return 48'({$urandom, $urandom} % total);
   endfunction

   function automatic longint out_total();
      longint t;
      int n;
      n = sb.axis_count == 0 ? 1 : (sb.axis_count > 4 ? 4 : sb.axis_count);
      t = 1;
      for (int i = 0; i < n; i++)
         t *= (i == sb.chosen_axis) ? (sb.chosen_count > 8 ? 8 : sb.chosen_count)
                                    : sb.extent[i];
      return t;
   endfunction

   // Response side: random stall per word, plus a long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (200) @(negedge clock);
            hold_off = 0;
         end else begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
               rsp_ready <= 0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1;
         @(negedge clock);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_src_index, rsp_out_of_range);

   initial begin
      logic [47:0] dir [$];
      int gap_max;
      sb = new();
      reset = 1;
      req_valid = 0;
      req_out_index = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      hold_off = 0;
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Reset settings: one element, index 0 fine, anything else out of range.
      send_word(48'd0, 0);
      send_word(48'd1, 0);
      send_word(48'hFFFF_FFFF_FFFF, 0);
      drain();

      // Maximum extents, 4 axes, table positions beyond the extent.
      load_config(3'd4, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 2'd3, 4'd8,
                  64'hFFEE_DDCC_BBAA_9988);
      dir = '{48'd0, 48'd7, 48'd8, 48'hFFFF_FFFF_FFFF, 48'h0FFF_FFFF_FFFF,
              48'h7FF7_FEFF_F007};
      foreach (dir[i]) send_word(dir[i], 0);
      drain();
      // Axis count zero and above maximum; chosen count saturates.
      load_config(3'd0, 12'd9, 12'd3, 12'd3, 12'd3, 2'd0, 4'd15,
                  64'h0102_0304_0506_0708);
      for (int i = 0; i < 10; i++) send_word(48'(i), 0);
      drain();
      csr_write(sagi_pkg::REG_AXIS_COUNT, 64'd7);
      send_word(48'd0, 0);
      send_word(48'd575, 0);
      send_word(48'd2000, 0);
      drain();
      // Zero extent and zero chosen count: all out of range.
      load_config(3'd2, 12'd0, 12'd5, 12'd1, 12'd1, 2'd1, 4'd3, 64'hFF);
      send_word(48'd0, 0);
      drain();
      csr_write(sagi_pkg::REG_EXTENT0, 64'd4);
      csr_write(sagi_pkg::REG_CHOSEN_COUNT, 64'd0);
      send_word(48'd0, 0);
      drain();
      // Chosen axis outside the axes in use: identity mapping; index 20 is one past the end, out of range.
      csr_write(sagi_pkg::REG_CHOSEN_COUNT, 64'd2);
      csr_write(sagi_pkg::REG_CHOSEN_AXIS, 64'd3);
      send_word(48'd19, 0);
      send_word(48'd20, 0);
      drain();

      // Random phases.
      for (int phase = 0; phase < 25; phase++) begin
         int n;
         logic [11:0] e [4];
         n = $urandom_range(0, 7);
         foreach (e[i])
            e[i] = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(0, 1) * 4095)
                   : ($urandom_range(0, 19) == 0 ? 12'd0 : 12'($urandom_range(1, 40)));
         load_config(3'(n), e[0], e[1], e[2], e[3], 2'($urandom),
                     4'($urandom_range(0, 15)), {$urandom, $urandom});
         gap_max = (phase % 4 == 0) ? 0 : 18;
         if (phase == 5) begin
            hold_off = 1;
            send_burst(120);
         end
         for (int k = 0; k < 65; k++)
            send_word(pick_index(out_total()), $urandom_range(0, gap_max));
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
